/* hw/rtl/dtt_pkg.sv */
// Shared package for the dirty tile tracker: command codes, field widths,
// arithmetic constants and the controller/datapath interface structs.
// No dependencies.
`timescale 1ns / 1ps

package dtt_pkg;

    // Default frame and tile geometry.
    localparam int DEF_FRAME_WIDTH  = 1920;
    localparam int DEF_FRAME_HEIGHT = 1080;
    localparam int DEF_TILE_WIDTH   = 32;
    localparam int DEF_TILE_HEIGHT  = 32;

    // Command codes carried on the input tuser.
    localparam logic [1:0] CMD_MARK     = 2'd0;
    localparam logic [1:0] CMD_CLEAR    = 2'd1;
    localparam logic [1:0] CMD_MARK_ALL = 2'd2;
    localparam logic [1:0] CMD_FINALIZE = 2'd3;

    // Port and field widths.
    localparam int CMD_W     = 2;
    localparam int RECT_W    = 16;
    localparam int S_TUSER_W = 2;
    localparam int S_TDATA_W = 64;
    localparam int CNT_OUT_W = 13;
    localparam int FRAMES_W  = 32;
    localparam int AVG_W     = 20;
    localparam int PCT_W     = 15;
    localparam int M_TDATA_W = 120;

    // Arithmetic constants.
    localparam int PCT_SCALE   = 25600;  // 100 percent in Q8
    localparam int AVG_SHIFT   = 3;      // 1/8 weight of the moving averages
    localparam int RECIP_SHIFT = 20;     // exact reciprocal division for 13-bit pixels
    localparam int RECIP_W     = 18;
    localparam int POS_W       = 13;     // clipped pixel positions
    localparam int CHUNK_W     = 16;     // popcount slice of one bitmap row

    localparam logic [AVG_W-1:0] AVG_MAX = '1;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_in;
        logic calc_clip;
        logic calc_tile;
        logic calc_mask;
        logic row_start;
        logic row_issue;
        logic sweep_start;
        logic sweep_wr;
        logic sweep_ones;
        logic fin_stats;
        logic div_start;
        logic fin_pct;
        logic out_load;
    } dtt_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             rect_ok;
        logic             row_last;
        logic             sweep_last;
        logic             pipe_busy;
        logic             div_done;
    } dtt_stat_t;

endpackage

/* hw/rtl/dtt_div.sv */
// Constant divider for the clean percentage: PCT_SCALE * num / DIVISOR by
// reciprocal multiplication, with a registered result.
// Depends on dtt_pkg for the scale and the quotient width.
`timescale 1ns / 1ps

module dtt_div import dtt_pkg::*; #(
    parameter int DEN_W   = 12,
    parameter int DIVISOR = 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DEN_W-1:0] num,
    output logic             done,
    output logic [PCT_W-1:0] quot
);

    // With num no larger than DIVISOR, a reciprocal rounded up and scaled by
    // 2^(2*DEN_W) keeps the error below 1/DIVISOR, so the floor is exact.
    localparam int     FRAC_W = 2 * DEN_W;
    localparam longint RECIP  = ((longint'(PCT_SCALE) << FRAC_W) + longint'(DIVISOR) - 1)
                                / longint'(DIVISOR);
    localparam int     PROD_W = FRAC_W + PCT_W;

    logic [PROD_W-1:0] prod;
    logic              done_reg;
    logic [PCT_W-1:0]  quot_reg;

    assign prod = PROD_W'(num) * PROD_W'(RECIP);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= start;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quot_reg <= prod[FRAC_W +: PCT_W];
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

/* hw/rtl/dtt_datapath.sv */
// Datapath of the dirty tile tracker: rectangle clipping, tile range,
// bitmap row memory with a count pipeline, frame statistics and output word.
// Depends on dtt_pkg and dtt_div.
`timescale 1ns / 1ps

module dtt_datapath import dtt_pkg::*; #(
    parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT,
    parameter int TILE_WIDTH   = DEF_TILE_WIDTH,
    parameter int TILE_HEIGHT  = DEF_TILE_HEIGHT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [S_TUSER_W-1:0] in_user,
    input  logic [S_TDATA_W-1:0] in_data,
    input  dtt_cmd_t             cmd,
    output dtt_stat_t            stat,
    output logic [M_TDATA_W-1:0] out_data
);

    localparam int TILES_X     = (FRAME_WIDTH + TILE_WIDTH - 1) / TILE_WIDTH;
    localparam int TILES_Y     = (FRAME_HEIGHT + TILE_HEIGHT - 1) / TILE_HEIGHT;
    localparam int TILES_TOTAL = TILES_X * TILES_Y;
    localparam int COL_W       = (TILES_X > 1) ? $clog2(TILES_X) : 1;
    localparam int ROW_AW      = (TILES_Y > 1) ? $clog2(TILES_Y) : 1;
    localparam int CNT_W       = $clog2(TILES_TOTAL + 1);
    localparam int RECIP_X     = ((1 << RECIP_SHIFT) + TILE_WIDTH - 1) / TILE_WIDTH;
    localparam int RECIP_Y     = ((1 << RECIP_SHIFT) + TILE_HEIGHT - 1) / TILE_HEIGHT;
    localparam int PROD_W      = POS_W + RECIP_W;
    localparam int NCHUNK      = (TILES_X + CHUNK_W - 1) / CHUNK_W;
    localparam int PAD_W       = NCHUNK * CHUNK_W;
    localparam int CCNT_W      = $clog2(CHUNK_W + 1);
    localparam int AD_W        = (((CNT_W + 8) > (AVG_W + 3)) ? (CNT_W + 8) : (AVG_W + 3)) + 1;
    localparam int AVOID_W     = (((CNT_W + 8) > AVG_W) ? (CNT_W + 8) : AVG_W) + 1;
    localparam int PA_W        = PCT_W + 3;

    localparam logic signed [17:0] FW_S = 18'(FRAME_WIDTH);
    localparam logic signed [17:0] FH_S = 18'(FRAME_HEIGHT);
    localparam logic [CNT_W-1:0]   TOTAL_V    = CNT_W'(TILES_TOTAL);
    localparam logic [ROW_AW-1:0]  ROW_LAST   = ROW_AW'(TILES_Y - 1);
    localparam logic [AVOID_W-1:0] AVOID_BASE = AVOID_W'(TILES_TOTAL * 256);

    // Latched input word.
    logic [CMD_W-1:0]         cmd_in_reg;
    logic signed [RECT_W-1:0] x_reg, y_reg, w_reg, h_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            cmd_in_reg <= in_user[CMD_W-1:0];
            x_reg      <= in_data[RECT_W-1:0];
            y_reg      <= in_data[2*RECT_W-1:RECT_W];
            w_reg      <= in_data[3*RECT_W-1:2*RECT_W];
            h_reg      <= in_data[4*RECT_W-1:3*RECT_W];
        end
    end

    // Clipping: the surviving span is [max(x,0), min(x+w, frame width)).
    logic signed [17:0] x_s, y_s, w_s, h_s, xe_s, ye_s;
    logic signed [17:0] xl_s, xr_s, yl_s, yr_s, xr_m1, yr_m1;
    logic               clip_ok;

    always_comb begin
        x_s     = 18'(x_reg);
        y_s     = 18'(y_reg);
        w_s     = 18'(w_reg);
        h_s     = 18'(h_reg);
        xe_s    = x_s + w_s;
        ye_s    = y_s + h_s;
        xl_s    = (x_s < 0) ? '0 : x_s;
        yl_s    = (y_s < 0) ? '0 : y_s;
        xr_s    = (xe_s > FW_S) ? FW_S : xe_s;
        yr_s    = (ye_s > FH_S) ? FH_S : ye_s;
        xr_m1   = xr_s - 18'sd1;
        yr_m1   = yr_s - 18'sd1;
        clip_ok = (w_s > 0) && (h_s > 0) && (xr_s > xl_s) && (yr_s > yl_s);
    end

    logic [POS_W-1:0] x_lo_reg, x_hi_reg, y_lo_reg, y_hi_reg;
    logic             rect_ok_reg;

    always_ff @(posedge aclk) begin
        if (cmd.calc_clip) begin
            x_lo_reg    <= xl_s[POS_W-1:0];
            x_hi_reg    <= xr_m1[POS_W-1:0];
            y_lo_reg    <= yl_s[POS_W-1:0];
            y_hi_reg    <= yr_m1[POS_W-1:0];
            rect_ok_reg <= clip_ok;
        end
    end

    // Pixel to tile index by an exact reciprocal multiply.
    logic [PROD_W-1:0] px0, px1, py0, py1;
    logic [COL_W-1:0]  tx0_reg, tx1_reg;
    logic [ROW_AW-1:0] ty0_reg, ty1_reg;

    assign px0 = PROD_W'(x_lo_reg) * PROD_W'(RECIP_X);
    assign px1 = PROD_W'(x_hi_reg) * PROD_W'(RECIP_X);
    assign py0 = PROD_W'(y_lo_reg) * PROD_W'(RECIP_Y);
    assign py1 = PROD_W'(y_hi_reg) * PROD_W'(RECIP_Y);

    always_ff @(posedge aclk) begin
        if (cmd.calc_tile) begin
            tx0_reg <= px0[RECIP_SHIFT +: COL_W];
            tx1_reg <= px1[RECIP_SHIFT +: COL_W];
            ty0_reg <= py0[RECIP_SHIFT +: ROW_AW];
            ty1_reg <= py1[RECIP_SHIFT +: ROW_AW];
        end
    end

    // Column mask of the rectangle, shared by all of its rows.
    logic [TILES_X-1:0] mask_next, mask_reg;

    always_comb begin
        for (int i = 0; i < TILES_X; i++) begin
            mask_next[i] = (COL_W'(i) >= tx0_reg) && (COL_W'(i) <= tx1_reg);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.calc_mask) begin
            mask_reg <= mask_next;
        end
    end

    // Row pointer for rectangle reads and for full sweeps.
    logic [ROW_AW-1:0] row_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
        end else begin
            priority if (cmd.sweep_start) begin
                row_reg <= '0;
            end else if (cmd.row_start) begin
                row_reg <= ty0_reg;
            end else if (cmd.row_issue || cmd.sweep_wr) begin
                row_reg <= row_reg + ROW_AW'(1);
            end
        end
    end

    // Bitmap memory, one tile row per entry.
    logic [TILES_X-1:0] tile_mem [TILES_Y];
    logic [TILES_X-1:0] rd_data_reg;
    logic               mem_we;
    logic [ROW_AW-1:0]  mem_wa;
    logic [TILES_X-1:0] mem_wd;
    logic               s1_valid_reg, s2_valid_reg, s3_valid_reg;
    logic [ROW_AW-1:0]  s1_addr_reg;

    always_comb begin
        mem_we = cmd.sweep_wr || s1_valid_reg;
        if (cmd.sweep_wr) begin
            mem_wa = row_reg;
            mem_wd = cmd.sweep_ones ? '1 : '0;
        end else begin
            mem_wa = s1_addr_reg;
            mem_wd = rd_data_reg | mask_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            tile_mem[mem_wa] <= mem_wd;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.row_issue) begin
            rd_data_reg <= tile_mem[row_reg];
            s1_addr_reg <= row_reg;
        end
    end

    // Count pipeline: new bits, per-slice popcounts, then the row sum.
    logic [TILES_X-1:0] new_bits_reg;
    logic [PAD_W-1:0]   nb_pad;
    logic [CCNT_W-1:0]  chunk_reg [NCHUNK];
    logic [CNT_W-1:0]   row_sum;

    assign nb_pad = PAD_W'(new_bits_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= cmd.row_issue;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_valid_reg) begin
            new_bits_reg <= mask_reg & ~rd_data_reg;
        end
        if (s2_valid_reg) begin
            for (int c = 0; c < NCHUNK; c++) begin
                chunk_reg[c] <= CCNT_W'($countones(nb_pad[c*CHUNK_W +: CHUNK_W]));
            end
        end
    end

    always_comb begin
        row_sum = '0;
        for (int c = 0; c < NCHUNK; c++) begin
            row_sum = row_sum + CNT_W'(chunk_reg[c]);
        end
    end

    // Frame statistics.
    logic [CNT_W-1:0]    count_reg, count_prev_reg;
    logic [FRAMES_W-1:0] frames_reg;
    logic [AVG_W-1:0]    avg_dirty_reg;
    logic [PCT_W-1:0]    avg_pct_reg;
    logic                seed_reg;
    logic [CNT_W-1:0]    num_reg;

    logic [AD_W-1:0]     ad_sample, ad_mix, ad_pick;
    logic [AVG_W-1:0]    ad_next;
    logic [PA_W-1:0]     pa_sum;
    logic                div_done;
    logic [PCT_W-1:0]    div_q;

    always_comb begin
        ad_sample = AD_W'({count_reg, 8'd0});
        ad_mix    = (AD_W'({avg_dirty_reg, 3'd0}) - AD_W'(avg_dirty_reg) + ad_sample)
                    >> AVG_SHIFT;
        ad_pick   = (frames_reg == '0) ? ad_sample : ad_mix;
        ad_next   = (ad_pick > AD_W'(AVG_MAX)) ? AVG_MAX : ad_pick[AVG_W-1:0];
        pa_sum    = PA_W'({avg_pct_reg, 3'd0}) - PA_W'(avg_pct_reg) + PA_W'(div_q);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg      <= '0;
            count_prev_reg <= '0;
            frames_reg     <= '0;
            avg_dirty_reg  <= '0;
            avg_pct_reg    <= '0;
            seed_reg       <= 1'b0;
        end else begin
            priority if (cmd.sweep_start) begin
                count_reg <= cmd.sweep_ones ? TOTAL_V : '0;
            end else if (s3_valid_reg) begin
                count_reg <= count_reg + row_sum;
            end
            if (cmd.fin_stats) begin
                count_prev_reg <= count_reg;
                frames_reg     <= frames_reg + FRAMES_W'(1);
                seed_reg       <= (frames_reg == '0);
                avg_dirty_reg  <= ad_next;
            end
            if (cmd.fin_pct) begin
                avg_pct_reg <= seed_reg ? div_q : pa_sum[PA_W-1:AVG_SHIFT];
            end
        end
    end

    // Clean tiles of the frame; the divider scales them to percent.
    always_ff @(posedge aclk) begin
        if (cmd.fin_stats) begin
            num_reg <= TOTAL_V - count_reg;
        end
    end

    dtt_div #(
        .DEN_W   (CNT_W),
        .DIVISOR (TILES_TOTAL)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .num     (num_reg),
        .done    (div_done),
        .quot    (div_q)
    );

    // Output word.
    logic [AVOID_W-1:0]   avoid_diff;
    logic [AVG_W-1:0]     avoided;
    logic [31:0]          now32, last32;
    logic [M_TDATA_W-1:0] out_data_reg;

    always_comb begin
        avoid_diff = (AVOID_BASE > AVOID_W'(avg_dirty_reg))
                     ? AVOID_BASE - AVOID_W'(avg_dirty_reg) : '0;
        avoided    = (avoid_diff > AVOID_W'(AVG_MAX)) ? AVG_MAX : avoid_diff[AVG_W-1:0];
        now32      = 32'(count_reg);
        last32     = 32'(count_prev_reg);
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            out_data_reg <= M_TDATA_W'({avg_pct_reg, avoided, avg_dirty_reg, frames_reg,
                                        last32[CNT_OUT_W-1:0], now32[CNT_OUT_W-1:0]});
        end
    end

    assign out_data = out_data_reg;

    assign stat.cmd        = cmd_in_reg;
    assign stat.rect_ok    = rect_ok_reg;
    assign stat.row_last   = (row_reg == ty1_reg);
    assign stat.sweep_last = (row_reg == ROW_LAST);
    assign stat.pipe_busy  = s1_valid_reg || s2_valid_reg || s3_valid_reg;
    assign stat.div_done   = div_done;

endmodule

/* hw/rtl/dtt_ctrl.sv */
// Controller state machine of the dirty tile tracker: sequences each
// command through the datapath and owns both handshakes. Depends on dtt_pkg.
`timescale 1ns / 1ps

module dtt_ctrl import dtt_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    output logic      m_tvalid,
    input  logic      m_tready,
    output dtt_cmd_t  cmd,
    input  dtt_stat_t stat
);

    localparam logic [3:0] S_INIT   = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_CLIP   = 4'd2;
    localparam logic [3:0] S_TILE   = 4'd3;
    localparam logic [3:0] S_MASK   = 4'd4;
    localparam logic [3:0] S_ROWS   = 4'd5;
    localparam logic [3:0] S_DRAIN  = 4'd6;
    localparam logic [3:0] S_SWEEP  = 4'd7;
    localparam logic [3:0] S_FSTART = 4'd8;
    localparam logic [3:0] S_FDIV   = 4'd9;
    localparam logic [3:0] S_DONE   = 4'd10;

    logic [3:0] state_reg, state_next;
    logic       m_tvalid_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_INIT: begin
                cmd.sweep_wr = 1'b1;
                if (stat.sweep_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = S_CLIP;
                end
            end
            S_CLIP: begin
                cmd.calc_clip = 1'b1;
                unique case (stat.cmd)
                    CMD_MARK: begin
                        state_next = S_TILE;
                    end
                    CMD_CLEAR: begin
                        cmd.sweep_start = 1'b1;
                        state_next      = S_SWEEP;
                    end
                    CMD_MARK_ALL: begin
                        cmd.sweep_start = 1'b1;
                        cmd.sweep_ones  = 1'b1;
                        state_next      = S_SWEEP;
                    end
                    CMD_FINALIZE: begin
                        cmd.fin_stats = 1'b1;
                        state_next    = S_FSTART;
                    end
                endcase
            end
            S_TILE: begin
                cmd.calc_tile = 1'b1;
                state_next    = stat.rect_ok ? S_MASK : S_DONE;
            end
            S_MASK: begin
                cmd.calc_mask = 1'b1;
                cmd.row_start = 1'b1;
                state_next    = S_ROWS;
            end
            S_ROWS: begin
                cmd.row_issue = 1'b1;
                if (stat.row_last) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!stat.pipe_busy) begin
                    state_next = S_DONE;
                end
            end
            S_SWEEP: begin
                cmd.sweep_wr   = 1'b1;
                cmd.sweep_ones = (stat.cmd == CMD_MARK_ALL);
                if (stat.sweep_last) begin
                    state_next = S_DONE;
                end
            end
            S_FSTART: begin
                cmd.div_start = 1'b1;
                state_next    = S_FDIV;
            end
            S_FDIV: begin
                if (stat.div_done) begin
                    cmd.fin_pct = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_INIT;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cmd.out_load) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

/* hw/rtl/dirty_tile_tracker.sv */
// Top level of the dirty tile tracker: joins the controller and the datapath.
// Depends on dtt_pkg, dtt_ctrl and dtt_datapath (which holds dtt_div).
`timescale 1ns / 1ps

// Usage
// The input channel takes one command word per handshake: s_tuser holds the
// command (mark rectangle, clear all, mark all, finalize frame) and s_tdata the
// signed rectangle, which is ignored by the other commands. Every accepted word
// produces exactly one result word on the output channel with the dirty count,
// the count latched at the last frame end, the frame counter and the moving
// averages of dirty tiles, avoided tiles and percent of clean tiles (Q8).
// Timing: a word is processed one at a time. A mark command reads and writes
// the bitmap memory one tile row per cycle over the tile rows that the clipped
// rectangle covers, then waits for the count pipeline to drain. Clear all and
// mark all sweep every tile row. Finalize updates the frame statistics, and
// the clean percentage comes from a registered reciprocal multiply.
// After reset a clearing pass writes zeros to every tile row while s_tready
// stays low.
// The result sits in an output register: when the receiver stalls, the next
// word is still accepted and processed, and its result waits until the
// earlier result has been taken.

module dirty_tile_tracker import dtt_pkg::*; #(
    parameter int FRAME_WIDTH  = DEF_FRAME_WIDTH,
    parameter int FRAME_HEIGHT = DEF_FRAME_HEIGHT,
    parameter int TILE_WIDTH   = DEF_TILE_WIDTH,
    parameter int TILE_HEIGHT  = DEF_TILE_HEIGHT
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    // Input channel.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [S_TDATA_W-1:0] s_tdata,  // rect_x, rect_y, rect_w, rect_h (16 bits each)
    input  logic [S_TUSER_W-1:0] s_tuser,  // cmd
    // Result channel.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_TDATA_W-1:0] m_tdata   // dirty_now, dirty_last_frame, frames_done,
                                           // avg_dirty_q8, avg_avoided_tiles_q8,
                                           // avg_pct_avoided_q8, zero pad
);

    dtt_cmd_t  cmd;
    dtt_stat_t stat;

    // The controller sequences each command and owns both handshakes.
    dtt_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    // The datapath holds the bitmap, the counters and the result register.
    dtt_datapath #(
        .FRAME_WIDTH  (FRAME_WIDTH),
        .FRAME_HEIGHT (FRAME_HEIGHT),
        .TILE_WIDTH   (TILE_WIDTH),
        .TILE_HEIGHT  (TILE_HEIGHT)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_user  (s_tuser),
        .in_data  (s_tdata),
        .cmd      (cmd),
        .stat     (stat),
        .out_data (m_tdata)
    );

endmodule
